>>> hdl/pnns_pkg.sv
// ----------------------------------------------------------------------------
// pnns_pkg
// Shared constants, codes and types of the palette nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package pnns_pkg;

  localparam int MAX_DISPLAY_DEF  = 1024;
  localparam int SRC_STRIDE_DEF   = 272;
  localparam int FRAME_ROWS_DEF   = 262;
  localparam int H_OFFSET_DEF     = 8;
  localparam int PALETTE_SIZE_DEF = 32;

  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int FUNC_W      = 2;
  localparam int ADDR_W      = 17;
  localparam int VALUE_W     = 32;
  localparam int COLOR_W     = 32;
  localparam int COORD_W     = 10;
  localparam int BYTE_W      = 8;
  localparam int COLOR_IDX_W = 5;

  localparam int FRAC_W  = 16;
  localparam int ACC_W   = 34;
  localparam int RATIO_W = 25;
  localparam int DVD_W   = 25;
  localparam int SY_W    = ACC_W - FRAC_W;
  localparam int SX_W    = SY_W + 1;

  localparam int SRC_VIS_W  = 256;
  localparam int SRC_VIS_H  = 240;
  localparam int RST_WIDTH  = 240;
  localparam int RST_HEIGHT = 320;

  localparam logic [DVD_W-1:0] DVD_X = DVD_W'(SRC_VIS_W) << FRAC_W;
  localparam logic [DVD_W-1:0] DVD_Y = DVD_W'(SRC_VIS_H) << FRAC_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_PAL   = 2'd1,
    FUNC_EMIT  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    OP_FRAME,
    OP_PAL,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
    logic [SX_W-1:0]    sx;
    logic [SY_W-1:0]    sy;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last;
  } qent_t;

endpackage

>>> hdl/pnns_if.sv
// ----------------------------------------------------------------------------
// pnns_if
// Valid/ready channels of the scaler: request items in, pixel items out.
// ----------------------------------------------------------------------------
interface pnns_in_if import pnns_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ADDR_W-1:0]  addr;
  logic [VALUE_W-1:0] value;

  modport source (output valid, func, addr, value, input ready);
  modport sink (input valid, func, addr, value, output ready);
endinterface

interface pnns_out_if import pnns_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic               last_of_frame;

  modport source (output valid, color, column, row, last_of_frame, input ready);
  modport sink (input valid, color, column, row, last_of_frame, output ready);
endinterface

>>> hdl/pnns_div.sv
// ----------------------------------------------------------------------------
// pnns_div
// Restoring divider, one quotient bit per cycle, for the scale ratios.
// ----------------------------------------------------------------------------
module pnns_div import pnns_pkg::*; #(
  parameter int SIZE_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DVD_W-1:0]  quot
);

  localparam int CntW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dvs_r, dvs_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SIZE_W:0]   rem_sh;
  logic [SIZE_W:0]   diff;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[DVD_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    ge       = rem_sh >= {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CntW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r || done_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

>>> hdl/pnns_front.sv
// ----------------------------------------------------------------------------
// pnns_front
// Accepts request items, holds size registers, ratios and raster position,
// and classifies each item into a queue entry, dropping spare codes and out-of-range writes.
// ----------------------------------------------------------------------------
module pnns_front import pnns_pkg::*; #(
  parameter int MAX_DISPLAY  = MAX_DISPLAY_DEF,
  parameter int SRC_STRIDE   = SRC_STRIDE_DEF,
  parameter int FRAME_ROWS   = FRAME_ROWS_DEF,
  parameter int H_OFFSET     = H_OFFSET_DEF,
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pnns_in_if.sink                              in_ch,
  input  logic                                 cfg_we,
  input  logic [CFG_IDX_W-1:0]                 cfg_idx,
  input  logic [CFG_W-1:0]                     cfg_data,
  input  logic                                 q_full,
  output logic                                 q_push,
  output qent_t                                q_ent,
  output logic                                 div_start,
  output logic [DVD_W-1:0]                     div_dividend,
  output logic [$clog2(MAX_DISPLAY+1)-1:0]     div_divisor,
  input  logic                                 div_busy,
  input  logic                                 div_done,
  input  logic [DVD_W-1:0]                     div_quot
);

  localparam int SizeW      = $clog2(MAX_DISPLAY + 1);
  localparam int CntW       = $clog2(MAX_DISPLAY);
  localparam int CmpW       = CntW + 1;
  localparam int FrameBytes = SRC_STRIDE * FRAME_ROWS;
  localparam int RstW       = (RST_WIDTH > MAX_DISPLAY) ? MAX_DISPLAY : RST_WIDTH;
  localparam int RstH       = (RST_HEIGHT > MAX_DISPLAY) ? MAX_DISPLAY : RST_HEIGHT;
  localparam int RstRatioX  = ((SRC_VIS_W << FRAC_W) / RstW) + 1;
  localparam int RstRatioY  = ((SRC_VIS_H << FRAC_W) / RstH) + 1;

  logic [SizeW-1:0]   width_r, width_nxt;
  logic [SizeW-1:0]   height_r, height_nxt;
  logic [RATIO_W-1:0] ratio_x_r, ratio_x_nxt;
  logic [RATIO_W-1:0] ratio_y_r, ratio_y_nxt;
  logic               pend_x_r, pend_x_nxt;
  logic               pend_y_r, pend_y_nxt;
  logic               dsel_r, dsel_nxt;
  logic [CntW-1:0]    col_r, col_nxt;
  logic [CntW-1:0]    row_r, row_nxt;
  logic [ACC_W-1:0]   cacc_r, cacc_nxt;
  logic [ACC_W-1:0]   racc_r, racc_nxt;

  logic               accept;
  logic               emit;
  logic               dsel;
  logic [CmpW-1:0]    col_inc;
  logic [CmpW-1:0]    row_inc;
  logic               col_wrap;
  logic               row_wrap;
  logic [RATIO_W-1:0] ratio_new;

  function automatic logic [SizeW-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (32'(v) > 32'(MAX_DISPLAY)) begin
      r = SizeW'(MAX_DISPLAY);
    end else begin
      r = SizeW'(v);
    end
    return r;
  endfunction

  assign in_ch.ready = !q_full && !div_busy && !pend_x_r && !pend_y_r;
  assign accept      = in_ch.valid && in_ch.ready;

  assign dsel         = !pend_x_r;
  assign div_start    = !div_busy && (pend_x_r || pend_y_r);
  assign div_dividend = dsel ? DVD_Y : DVD_X;
  assign div_divisor  = dsel ? height_r : width_r;
  assign ratio_new    = RATIO_W'(div_quot) + RATIO_W'(1);

  always_comb begin
    col_inc  = CmpW'(col_r) + CmpW'(1);
    row_inc  = CmpW'(row_r) + CmpW'(1);
    col_wrap = col_inc >= CmpW'(width_r);
    row_wrap = row_inc >= CmpW'(height_r);

    q_ent.op     = OP_EMIT;
    q_ent.addr   = in_ch.addr;
    q_ent.data   = in_ch.value;
    q_ent.sx     = SX_W'(cacc_r[ACC_W-1:FRAC_W]) + SX_W'(H_OFFSET);
    q_ent.sy     = racc_r[ACC_W-1:FRAC_W];
    q_ent.column = COORD_W'(col_r);
    q_ent.row    = COORD_W'(row_r);
    q_ent.last   = (col_inc == CmpW'(width_r)) && (row_inc == CmpW'(height_r));

    emit   = 1'b0;
    q_push = 1'b0;
    case (func_t'(in_ch.func))
      FUNC_FRAME: begin
        q_ent.op = OP_FRAME;
        q_push   = accept && (32'(in_ch.addr) < 32'(FrameBytes));
      end
      FUNC_PAL: begin
        q_ent.op = OP_PAL;
        q_push   = accept && (32'(in_ch.addr) < 32'(PALETTE_SIZE));
      end
      FUNC_EMIT: begin
        q_ent.op = OP_EMIT;
        q_push   = accept;
        emit     = accept;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    ratio_x_nxt = ratio_x_r;
    ratio_y_nxt = ratio_y_r;
    pend_x_nxt  = pend_x_r;
    pend_y_nxt  = pend_y_r;
    dsel_nxt    = dsel_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    cacc_nxt    = cacc_r;
    racc_nxt    = racc_r;

    if (div_start) begin
      dsel_nxt = dsel;
      if (dsel) begin
        pend_y_nxt = 1'b0;
      end else begin
        pend_x_nxt = 1'b0;
      end
    end
    if (div_done) begin
      if (dsel_r) begin
        ratio_y_nxt = ratio_new;
      end else begin
        ratio_x_nxt = ratio_new;
      end
    end

    if (cfg_we && (cfg_idx == CFG_IDX_WIDTH || cfg_idx == CFG_IDX_HEIGHT)) begin
      if (cfg_idx == CFG_IDX_WIDTH) begin
        width_nxt  = clamp_size(cfg_data);
        pend_x_nxt = 1'b1;
      end else begin
        height_nxt = clamp_size(cfg_data);
        pend_y_nxt = 1'b1;
      end
      col_nxt  = '0;
      row_nxt  = '0;
      cacc_nxt = '0;
      racc_nxt = '0;
    end else if (emit) begin
      if (col_wrap) begin
        col_nxt  = '0;
        cacc_nxt = '0;
        if (row_wrap) begin
          row_nxt  = '0;
          racc_nxt = '0;
        end else begin
          row_nxt  = row_r + CntW'(1);
          racc_nxt = racc_r + ACC_W'(ratio_y_r);
        end
      end else begin
        col_nxt  = col_r + CntW'(1);
        cacc_nxt = cacc_r + ACC_W'(ratio_x_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= SizeW'(RstW);
      height_r  <= SizeW'(RstH);
      ratio_x_r <= RATIO_W'(RstRatioX);
      ratio_y_r <= RATIO_W'(RstRatioY);
      pend_x_r  <= 1'b0;
      pend_y_r  <= 1'b0;
      dsel_r    <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      cacc_r    <= '0;
      racc_r    <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      ratio_x_r <= ratio_x_nxt;
      ratio_y_r <= ratio_y_nxt;
      pend_x_r  <= pend_x_nxt;
      pend_y_r  <= pend_y_nxt;
      dsel_r    <= dsel_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      cacc_r    <= cacc_nxt;
      racc_r    <= racc_nxt;
    end
  end

endmodule

>>> hdl/pnns_queue.sv
// ----------------------------------------------------------------------------
// pnns_queue
// Short first-in first-out queue of classified entries between the two parts.
// ----------------------------------------------------------------------------
module pnns_queue import pnns_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output qent_t head_ent
);

  qent_t             q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_pop;

  assign full     = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid    = cnt_r != '0;
  assign head_ent = q_r[rp_r];
  assign do_pop   = pop && valid;

  always_comb begin
    wp_nxt  = push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_ent;
    end
  end

endmodule

>>> hdl/pnns_back.sv
// ----------------------------------------------------------------------------
// pnns_back
// Three-stage back part: source address, frame store access, palette access.
// The output register is the last stage; all stages advance together.
// ----------------------------------------------------------------------------
module pnns_back import pnns_pkg::*; #(
  parameter int SRC_STRIDE   = SRC_STRIDE_DEF,
  parameter int FRAME_ROWS   = FRAME_ROWS_DEF,
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  qent_t      q_ent,
  output logic       q_pop,
  pnns_out_if.source out_ch
);

  localparam int FrameBytes = SRC_STRIDE * FRAME_ROWS;
  localparam int FaW        = $clog2(FrameBytes);
  localparam int PalAW      = $clog2(PALETTE_SIZE);
  localparam int ProdW      = SY_W + $clog2(SRC_STRIDE + 1);
  localparam int SrcW       = ProdW + 1;

  logic [BYTE_W-1:0]  frame_mem [FrameBytes];
  logic [COLOR_W-1:0] pal_mem [PALETTE_SIZE];

  logic               adv;
  logic               s1_vld_r;
  qent_t              s1_ent_r;
  logic [ProdW-1:0]   s1_prod_r;
  logic               s2_vld_r;
  qent_t              s2_ent_r;
  logic               s2_inr_r;
  logic [BYTE_W-1:0]  frd_r;
  logic               s3_vld_r;
  logic [COORD_W-1:0] s3_col_r;
  logic [COORD_W-1:0] s3_row_r;
  logic               s3_last_r;
  logic [COLOR_W-1:0] color_r;

  logic [SrcW-1:0]        src;
  logic                   inr;
  logic [FaW-1:0]         fa;
  logic                   fr_we;
  logic                   fr_re;
  logic [COLOR_IDX_W-1:0] pidx;
  logic [PalAW-1:0]       pa;
  logic                   pal_we;
  logic                   pal_re;

  assign adv   = !s3_vld_r || out_ch.ready;
  assign q_pop = adv;

  always_comb begin
    src    = SrcW'(s1_prod_r) + SrcW'(s1_ent_r.sx);
    inr    = src < SrcW'(FrameBytes);
    fa     = (s1_ent_r.op == OP_FRAME) ? FaW'(s1_ent_r.addr) : FaW'(src);
    fr_we  = adv && s1_vld_r && (s1_ent_r.op == OP_FRAME);
    fr_re  = adv && s1_vld_r && (s1_ent_r.op == OP_EMIT);
    pidx   = s2_inr_r ? frd_r[COLOR_IDX_W-1:0] : '0;
    pa     = (s2_ent_r.op == OP_PAL) ? PalAW'(s2_ent_r.addr) : PalAW'(pidx);
    pal_we = adv && s2_vld_r && (s2_ent_r.op == OP_PAL);
    pal_re = adv && s2_vld_r && (s2_ent_r.op == OP_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= q_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && (s2_ent_r.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ent_r  <= q_ent;
      s1_prod_r <= ProdW'(q_ent.sy) * ProdW'(SRC_STRIDE);
      s2_ent_r  <= s1_ent_r;
      s2_inr_r  <= inr;
      s3_col_r  <= s2_ent_r.column;
      s3_row_r  <= s2_ent_r.row;
      s3_last_r <= s2_ent_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      frame_mem[fa] <= s1_ent_r.data[BYTE_W-1:0];
    end
    if (fr_re) begin
      frd_r <= frame_mem[fa];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pa] <= s2_ent_r.data;
    end
    if (pal_re) begin
      color_r <= pal_mem[pa];
    end
  end

  assign out_ch.valid         = s3_vld_r;
  assign out_ch.color         = color_r;
  assign out_ch.column        = s3_col_r;
  assign out_ch.row           = s3_row_r;
  assign out_ch.last_of_frame = s3_last_r;

endmodule

>>> hdl/palette_nearest_neighbor_scaler_unit.sv
// ----------------------------------------------------------------------------
// palette_nearest_neighbor_scaler_unit
// Indexed-frame nearest-neighbor scaler with palette lookup.
// ----------------------------------------------------------------------------
// in_ch carries request items: frame byte writes, palette writes and pixel
// emits. Writes produce nothing; each emit produces one item on out_ch with
// the palette color, display column/row and an end-of-frame flag, in raster
// order. cfg_we/cfg_idx/cfg_data set display width (index 0) or height
// (index 1); a write restarts the raster at (0,0) and recomputes that ratio
// in a bit-serial divider, holding in_ch.ready low until the new ratio is in.
// Throughput: one item per cycle while out_ch is ready and no ratio is being
// recomputed, set by the single port of the frame store and of the palette.
// Reset: raster at (0,0), size 240 x 320 with ratios preloaded, frame store
// and palette contents undefined until written.
// A stalled out_ch freezes the back pipeline; the 4-entry queue then fills
// and in_ch.ready drops.
// ----------------------------------------------------------------------------
module palette_nearest_neighbor_scaler_unit import pnns_pkg::*; #(
  parameter int MAX_DISPLAY  = MAX_DISPLAY_DEF,
  parameter int SRC_STRIDE   = SRC_STRIDE_DEF,
  parameter int FRAME_ROWS   = FRAME_ROWS_DEF,
  parameter int H_OFFSET     = H_OFFSET_DEF,
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pnns_in_if.sink              in_ch,
  pnns_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SizeW = $clog2(MAX_DISPLAY + 1);

  logic             q_push;
  qent_t            q_in_ent;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  qent_t            q_head;
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [SizeW-1:0] div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;

  pnns_div #(
    .SIZE_W (SizeW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  pnns_front #(
    .MAX_DISPLAY  (MAX_DISPLAY),
    .SRC_STRIDE   (SRC_STRIDE),
    .FRAME_ROWS   (FRAME_ROWS),
    .H_OFFSET     (H_OFFSET),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_ent        (q_in_ent),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_done     (div_done),
    .div_quot     (div_quot)
  );

  pnns_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_in_ent),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_ent (q_head)
  );

  pnns_back #(
    .SRC_STRIDE   (SRC_STRIDE),
    .FRAME_ROWS   (FRAME_ROWS),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ent   (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/scaler_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scaler_pixel_checker
// Watches the request, pixel and register ports of the scaler, keeps its own
// frame, palette and raster state, predicts each display pixel and compares
// every accepted pixel field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module scaler_pixel_checker import pnns_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pnns_in_if                   in_mon,
  pnns_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pixels_owed
);

  localparam int FRAME_BYTES = SRC_STRIDE_DEF * FRAME_ROWS_DEF;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last;
  } pixel_t;

  logic [BYTE_W-1:0]  frame_mem [FRAME_BYTES];
  logic [COLOR_W-1:0] palette_mem [PALETTE_SIZE_DEF];
  logic [CFG_W-1:0]   width_px;
  logic [CFG_W-1:0]   height_px;
  logic [COORD_W-1:0] col_pos;
  logic [COORD_W-1:0] row_pos;
  logic [ACC_W-1:0]   col_acc;
  logic [ACC_W-1:0]   row_acc;
  logic [RATIO_W-1:0] col_step;
  logic [RATIO_W-1:0] row_step;
  pixel_t             pixels_due [$];
  int                 fail_total = 0;

  function automatic logic [CFG_W-1:0] size_in_range(logic [CFG_W-1:0] v);
    if (v == 0) return CFG_W'(1);
    if (v > MAX_DISPLAY_DEF) return CFG_W'(MAX_DISPLAY_DEF);
    return v;
  endfunction

  task automatic restart_raster();
    col_step = RATIO_W'((longint'(SRC_VIS_W) << FRAC_W) / width_px + 1);
    row_step = RATIO_W'((longint'(SRC_VIS_H) << FRAC_W) / height_px + 1);
    col_pos  = '0;
    row_pos  = '0;
    col_acc  = '0;
    row_acc  = '0;
  endtask

  task automatic flag(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_total++;
  endtask

  task automatic predict_pixel();
    int                src;
    logic [BYTE_W-1:0] idx_byte;
    pixel_t            px;
    src = int'(row_acc >> FRAC_W) * SRC_STRIDE_DEF + int'(col_acc >> FRAC_W) + H_OFFSET_DEF;
    idx_byte  = (src < FRAME_BYTES) ? frame_mem[src] : '0;
    px.color  = palette_mem[idx_byte[COLOR_IDX_W-1:0]];
    px.column = col_pos;
    px.row    = row_pos;
    px.last   = ({1'b0, col_pos} + 1 == width_px) && ({1'b0, row_pos} + 1 == height_px);
    pixels_due.push_back(px);
    // advance in raster order, wrap at end of line and frame
    if ({1'b0, col_pos} + 1 >= width_px) begin
      col_pos = '0;
      col_acc = '0;
      if ({1'b0, row_pos} + 1 >= height_px) begin
        row_pos = '0;
        row_acc = '0;
      end else begin
        row_pos = row_pos + 1'b1;
        row_acc = row_acc + row_step;
      end
    end else begin
      col_pos = col_pos + 1'b1;
      col_acc = col_acc + col_step;
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pixels_due.size() == 0) begin
      flag($sformatf("pixel (%0d,%0d) with nothing expected", out_mon.column, out_mon.row));
      return;
    end
    want = pixels_due.pop_front();
    if (out_mon.color !== want.color)
      flag($sformatf("color %08h, want %08h at (%0d,%0d)",
                     out_mon.color, want.color, want.column, want.row));
    if (out_mon.column !== want.column)
      flag($sformatf("column %0d, want %0d", out_mon.column, want.column));
    if (out_mon.row !== want.row)
      flag($sformatf("row %0d, want %0d", out_mon.row, want.row));
    if (out_mon.last_of_frame !== want.last)
      flag($sformatf("last_of_frame %0b, want %0b at (%0d,%0d)",
                     out_mon.last_of_frame, want.last, want.column, want.row));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pixels_due.delete();
      width_px  = CFG_W'(RST_WIDTH);
      height_px = CFG_W'(RST_HEIGHT);
      restart_raster();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_IDX_WIDTH) width_px = size_in_range(cfg_data);
        else height_px = size_in_range(cfg_data);
        restart_raster();
      end
      if (out_mon.valid && out_mon.ready) check_pixel();
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.func)
          FUNC_FRAME: begin
            if (in_mon.addr < FRAME_BYTES) frame_mem[in_mon.addr] = in_mon.value[BYTE_W-1:0];
          end
          FUNC_PAL: begin
            if (in_mon.addr < PALETTE_SIZE_DEF)
              palette_mem[in_mon.addr[COLOR_IDX_W-1:0]] = in_mon.value;
          end
          FUNC_EMIT: begin
            predict_pixel();
          end
          default: begin
          end
        endcase
      end
    end
    mismatches  <= fail_total;
    pixels_owed <= pixels_due.size();
  end

endmodule

>>> tb/palette_nearest_neighbor_scaler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_nearest_neighbor_scaler_unit_tb
// Drives frame, palette and pixel requests into the scaler through a range
// of display sizes, with random gaps and stalls on both channels, and leaves
// prediction and comparison to the pixel checker.
// ----------------------------------------------------------------------------
module palette_nearest_neighbor_scaler_unit_tb;
  import pnns_pkg::*;

  localparam int                FRAME_BYTES    = SRC_STRIDE_DEF * FRAME_ROWS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_SPARE     = 2'd3;
  localparam int                DRAIN_CYCLES   = 8;
  localparam int                LONG_HOLD      = 120;
  localparam int                WATCHDOG_LIMIT = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   pixels_owed;
  int                   stall_cycles = 0;
  bit                   calm = 1'b0;
  bit                   hold_req = 1'b0;

  // raster position of the next pixel request, to know which bytes it reads
  logic [CFG_W-1:0]     ras_w;
  logic [CFG_W-1:0]     ras_h;
  logic [COORD_W-1:0]   ras_col;
  logic [COORD_W-1:0]   ras_row;
  logic [ACC_W-1:0]     ras_cacc;
  logic [ACC_W-1:0]     ras_racc;
  logic [RATIO_W-1:0]   ras_cstep;
  logic [RATIO_W-1:0]   ras_rstep;
  logic [BYTE_W-1:0]    frame_copy [FRAME_BYTES];
  bit                   frame_set [FRAME_BYTES];
  bit                   pal_set [PALETTE_SIZE_DEF];

  pnns_in_if  in_ch ();
  pnns_out_if out_ch ();

  palette_nearest_neighbor_scaler_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  scaler_pixel_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pixels_owed (pixels_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic int raster_src();
    return int'(ras_racc >> FRAC_W) * SRC_STRIDE_DEF + int'(ras_cacc >> FRAC_W) + H_OFFSET_DEF;
  endfunction

  function automatic logic [ADDR_W-1:0] frame_target();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return ADDR_W'(raster_src() + $urandom_range(0, 40));
    if (r < 8) return ADDR_W'($urandom_range(0, FRAME_BYTES - 1));
    return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
  endfunction

  task automatic restart_raster();
    ras_cstep = RATIO_W'((longint'(SRC_VIS_W) << FRAC_W) / ras_w + 1);
    ras_rstep = RATIO_W'((longint'(SRC_VIS_H) << FRAC_W) / ras_h + 1);
    ras_col   = '0;
    ras_row   = '0;
    ras_cacc  = '0;
    ras_racc  = '0;
  endtask

  task automatic send_item(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a, logic [VALUE_W-1:0] v);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.addr  <= a;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_frame(logic [ADDR_W-1:0] a, logic [VALUE_W-1:0] v);
    send_item(FUNC_FRAME, a, v);
    if (a < FRAME_BYTES) begin
      frame_copy[a] = v[BYTE_W-1:0];
      frame_set[a]  = 1'b1;
    end
  endtask

  task automatic write_palette(logic [ADDR_W-1:0] a, logic [VALUE_W-1:0] v);
    send_item(FUNC_PAL, a, v);
    if (a < PALETTE_SIZE_DEF) pal_set[a[COLOR_IDX_W-1:0]] = 1'b1;
  endtask

  task automatic emit_pixel(logic [ADDR_W-1:0] a, logic [VALUE_W-1:0] v);
    int                src;
    logic [BYTE_W-1:0] b;
    src = raster_src();
    // fill the source byte and its palette entry before the first read
    if (!frame_set[src]) write_frame(ADDR_W'(src), $urandom);
    b = frame_copy[src];
    if (!pal_set[b[COLOR_IDX_W-1:0]]) write_palette(ADDR_W'(b[COLOR_IDX_W-1:0]), $urandom);
    send_item(FUNC_EMIT, a, v);
    if ({1'b0, ras_col} + 1 >= ras_w) begin
      ras_col  = '0;
      ras_cacc = '0;
      if ({1'b0, ras_row} + 1 >= ras_h) begin
        ras_row  = '0;
        ras_racc = '0;
      end else begin
        ras_row  = ras_row + 1'b1;
        ras_racc = ras_racc + ras_rstep;
      end
    end else begin
      ras_col  = ras_col + 1'b1;
      ras_cacc = ras_cacc + ras_cstep;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pixels_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    logic [CFG_W-1:0] fit;
    fit = (d == 0) ? CFG_W'(1) : (d > MAX_DISPLAY_DEF) ? CFG_W'(MAX_DISPLAY_DEF) : d;
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_WIDTH) ras_w = fit;
    else ras_h = fit;
    restart_raster();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic run_phase(int w, int h, int n, bit quiet, bit squeeze, bit pause);
    int done;
    int pick;
    settle();
    if (w >= 0) write_size(CFG_IDX_WIDTH, CFG_W'(w));
    if (h >= 0) write_size(CFG_IDX_HEIGHT, CFG_W'(h));
    calm = quiet;
    if (squeeze) hold_req = 1'b1;
    done = 0;
    while (done < n) begin
      if (pause && done == n / 2) settle();
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        emit_pixel(ADDR_W'($urandom), $urandom);
        done++;
      end else if (pick < 77) begin
        write_frame(frame_target(), $urandom);
        done++;
      end else if (pick < 90) begin
        write_palette(($urandom_range(0, 9) < 8) ? ADDR_W'($urandom_range(0, 31))
                                                 : ADDR_W'($urandom),
                      ($urandom_range(0, 9) == 0) ? '1 : $urandom);
        done++;
      end else begin
        send_item(FUNC_SPARE, ADDR_W'($urandom), $urandom);
      end
    end
    calm = 1'b0;
  endtask

  initial begin : pixel_sink
    int run_len;
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      run_len = calm ? 32 : $urandom_range(1, 16);
      repeat (run_len) @(posedge clk);
      stall = gap_len();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : request_source
    in_ch.valid = 1'b0;
    in_ch.func  = FUNC_FRAME;
    in_ch.addr  = '0;
    in_ch.value = '0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_IDX_WIDTH;
    cfg_data    = '0;
    rst_n       = 1'b0;
    ras_w       = CFG_W'(RST_WIDTH);
    ras_h       = CFG_W'(RST_HEIGHT);
    restart_raster();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, dropped writes, spare code, first pixels
    write_palette('0, '0);
    write_palette(ADDR_W'(PALETTE_SIZE_DEF - 1), '1);
    write_palette(ADDR_W'(PALETTE_SIZE_DEF), $urandom);
    write_palette('1, $urandom);
    write_frame('0, '1);
    write_frame(ADDR_W'(FRAME_BYTES - 1), '0);
    write_frame(ADDR_W'(FRAME_BYTES), $urandom);
    write_frame('1, '1);
    send_item(FUNC_SPARE, '1, '1);
    send_item(FUNC_SPARE, '0, '0);
    write_frame(ADDR_W'(H_OFFSET_DEF), 32'hFFFF_FF00);
    emit_pixel('0, '0);
    emit_pixel('1, '1);
    repeat (8) emit_pixel(ADDR_W'($urandom), $urandom);

    run_phase(0, 0, 40, 1'b0, 1'b0, 1'b0);
    run_phase(3, 2, 60, 1'b0, 1'b0, 1'b1);
    run_phase(2047, 1, 40, 1'b0, 1'b0, 1'b0);
    run_phase(1, 2047, 40, 1'b0, 1'b0, 1'b0);
    run_phase(1024, 1024, 30, 1'b0, 1'b0, 1'b0);
    run_phase(5, 3, 50, 1'b0, 1'b0, 1'b0);
    run_phase(-1, 4, 40, 1'b0, 1'b0, 1'b0);
    run_phase(7, -1, 40, 1'b0, 1'b0, 1'b0);
    run_phase(6, 2, 80, 1'b1, 1'b1, 1'b0);
    run_phase(17, 5, 50, 1'b0, 1'b0, 1'b1);
    run_phase(256, 240, 30, 1'b0, 1'b0, 1'b0);
    settle();

    if (mismatches == 0 && pixels_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
